// ----- sv/assert_macros.svh -----
// assertion macros used by the block's top-level rtl file
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/iwsad_pkg.sv -----
// shared constants and payload types of the incremental window sad matcher
// no dependencies
package iwsad_pkg;

   // default configuration
   localparam int WINDOW_SIZE_DEF = 5;
   localparam int DISPARITIES_DEF = 8;

   // fixed field widths
   localparam int PIX_W      = 8;
   localparam int PIX_MAX    = (1 << PIX_W) - 1;
   localparam int COL_DATA_W = 40;
   localparam int COL_IDX_W  = 12;
   localparam int DISP_W     = 3;
   localparam int SAD_W      = 13;
   localparam logic [SAD_W-1:0] SAD_MAX = '1;

   // request payload
   typedef struct packed {
      logic [COL_DATA_W-1:0] left_column;
      logic [COL_DATA_W-1:0] right_column;
      logic [COL_IDX_W-1:0]  column_index;
      logic                  row_start;
   } req_payload_type;

   // response payload
   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic [SAD_W-1:0]  window_sad;
      logic              last;
   } rsp_payload_type;

endpackage

// ----- sv/iwsad_chan_if.sv -----
// valid/ready channel carrying one payload of a chosen type
// payload types come from iwsad_pkg at the point of instantiation
interface iwsad_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/iwsad_col_sad.sv -----
// column sad: sum of absolute byte differences over one window column
// depends on iwsad_pkg
module iwsad_col_sad #(
   parameter int WINDOW_SIZE = iwsad_pkg::WINDOW_SIZE_DEF,
   localparam int COL_BITS = iwsad_pkg::PIX_W * WINDOW_SIZE,
   localparam int CSUM_W = $clog2(WINDOW_SIZE * iwsad_pkg::PIX_MAX + 1)
) (
   input  logic [COL_BITS-1:0] left_pixels,
   input  logic [COL_BITS-1:0] right_pixels,
   input  logic                force_zero,
   output logic [CSUM_W-1:0]   column_sad
);
   import iwsad_pkg::*;

   logic [PIX_W-1:0]  pix_a;
   logic [PIX_W-1:0]  pix_b;
   logic [PIX_W-1:0]  pix_diff;
   logic [CSUM_W-1:0] acc;

   // absolute differences summed row by row
   always_comb begin
      acc      = '0;
      pix_a    = '0;
      pix_b    = '0;
      pix_diff = '0;
      for (int r = 0; r < WINDOW_SIZE; r++) begin
         pix_a    = left_pixels[r*PIX_W +: PIX_W];
         pix_b    = right_pixels[r*PIX_W +: PIX_W];
         pix_diff = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
         acc      = acc + CSUM_W'(pix_diff);
      end
      column_sad = force_zero ? '0 : acc;
   end

endmodule

// ----- sv/incremental_window_sad_disparity.sv -----
// incremental window sad stereo matcher, top level
// depends on iwsad_pkg, iwsad_chan_if, iwsad_col_sad, assert_macros.svh
//
//   channel   dir   payload                                            per column
//   req_chan  in    left_column right_column column_index row_start    1 request
//   rsp_chan  out   disparity window_sad last                          DISPARITIES
//
// one disparity per cycle goes through the read-modify-write pipeline of the
// history and running-sum memories while the response is not stalled.
// a request passes the item register, then right-column read, history read
// and the output register before its first response is valid.
// reset clears control and the valid bits at once; there is no clearing pass.
// a stalled response freezes the sequencer, stages b and c and the output; the
// next request is taken while the last disparity of the current one issues.
`include "assert_macros.svh"

module incremental_window_sad_disparity #(
   parameter int WINDOW_SIZE = iwsad_pkg::WINDOW_SIZE_DEF,
   parameter int DISPARITIES = iwsad_pkg::DISPARITIES_DEF
) (
   input logic          clock,
   input logic          reset,
   iwsad_chan_if.sink   req_chan,
   iwsad_chan_if.source rsp_chan
);
   import iwsad_pkg::*;

   localparam int DW       = (DISPARITIES > 1) ? $clog2(DISPARITIES) : 1;
   localparam int HW       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int HAW      = DW + HW;
   localparam int HDEPTH   = DISPARITIES << HW;
   localparam int COL_BITS = PIX_W * WINDOW_SIZE;
   localparam int CSUM_W   = $clog2(WINDOW_SIZE * PIX_MAX + 1);
   localparam int RSUM_W   = $clog2(WINDOW_SIZE * WINDOW_SIZE * PIX_MAX + 1);
   localparam int CMP_W    = (RSUM_W > SAD_W) ? RSUM_W : SAD_W;
   localparam logic [DW-1:0] D_LAST = DW'(DISPARITIES - 1);
   localparam logic [HW-1:0] H_LAST = HW'(WINDOW_SIZE - 1);
   localparam logic [DISP_W-1:0] DISP_TOP = DISP_W'(DISPARITIES - 1);

   // pipeline enable: output register free or being emptied
   logic adv;
   logic issue;
   logic op_last;
   logic req_fire;

   // current request and disparity sequencer
   logic                 cur_valid_ff;
   logic [COL_BITS-1:0]  cur_left_ff;
   logic [COL_BITS-1:0]  cur_right_ff;
   logic [COL_IDX_W-1:0] cur_col_ff;
   logic                 cur_fresh_ff;
   logic [DW-1:0]        d_ff;
   logic [DW-1:0]        wp_ff;
   logic [HW-1:0]        hp_ff;
   logic                 boot_ff;

   // right column store
   logic [COL_BITS-1:0]    right_mem [DISPARITIES];
   logic [DISPARITIES-1:0] right_vld_ff;
   logic [DW:0]            ra_wrap;
   logic [DW-1:0]          ra;

   // stage b
   logic                b_valid_ff;
   logic [DW-1:0]       b_d_ff;
   logic [HW-1:0]       b_h_ff;
   logic                b_fresh_ff;
   logic                b_zero_ff;
   logic [COL_BITS-1:0] b_left_ff;
   logic [COL_BITS-1:0] b_new_right_ff;
   logic [COL_BITS-1:0] rd_right_ff;
   logic                b_rvld_ff;
   logic [COL_BITS-1:0] b_right_sel;
   logic [CSUM_W-1:0]   b_col_sad;
   logic [HAW-1:0]      b_haddr;

   // history and running-sum memories
   logic [CSUM_W-1:0] hist_mem [HDEPTH];
   logic [HDEPTH-1:0] hist_vld_ff;
   logic [RSUM_W-1:0] run_mem [DISPARITIES];

   // stage c
   logic              c_valid_ff;
   logic [DW-1:0]     c_d_ff;
   logic [HW-1:0]     c_h_ff;
   logic              c_fresh_ff;
   logic [CSUM_W-1:0] c_col_sad_ff;
   logic [CSUM_W-1:0] rd_hist_ff;
   logic              c_hvld_ff;
   logic [RSUM_W-1:0] rd_run_ff;
   logic              c_hfwd_ff;
   logic [CSUM_W-1:0] c_hfwd_data_ff;
   logic              c_rfwd_ff;
   logic [RSUM_W-1:0] c_rfwd_data_ff;
   logic              c_wr;
   logic [HAW-1:0]    c_haddr;
   logic [CSUM_W-1:0] c_leaving;
   logic [RSUM_W-1:0] c_run_old;
   logic [RSUM_W-1:0] c_new_run;
   logic [CMP_W-1:0]  c_run_ext;
   logic [SAD_W-1:0]  c_sad_out;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // assertion helpers
   logic bc_pair;
   logic rsp_is_last;

   // handshake control
   assign adv      = !rsp_valid_ff || rsp_chan.ready;
   assign issue    = adv && cur_valid_ff;
   assign op_last  = (d_ff == D_LAST);
   assign req_chan.ready = !cur_valid_ff || (issue && op_last);
   assign req_fire = req_chan.valid && req_chan.ready;

   // sequencer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         d_ff         <= '0;
         wp_ff        <= '0;
         hp_ff        <= '0;
         boot_ff      <= 1'b1;
      end else if (req_fire) begin
         cur_valid_ff <= 1'b1;
         d_ff         <= '0;
         wp_ff        <= (wp_ff == D_LAST) ? '0 : wp_ff + DW'(1);
         hp_ff        <= (hp_ff == H_LAST) ? '0 : hp_ff + HW'(1);
         boot_ff      <= 1'b0;
      end else if (issue) begin
         if (op_last) begin
            cur_valid_ff <= 1'b0;
         end else begin
            d_ff <= d_ff + DW'(1);
         end
      end
   end

   // request payload; the first request after reset acts as a row start
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_left_ff  <= COL_BITS'(req_chan.data.left_column);
         cur_right_ff <= COL_BITS'(req_chan.data.right_column);
         cur_col_ff   <= req_chan.data.column_index;
         cur_fresh_ff <= req_chan.data.row_start || boot_ff;
      end
   end

   // slot d lives d entries behind the current write pointer
   always_comb begin
      ra_wrap = {1'b0, wp_ff} + (DW+1)'(DISPARITIES) - {1'b0, d_ff};
      ra      = (wp_ff >= d_ff) ? (wp_ff - d_ff) : ra_wrap[DW-1:0];
   end

   // right column memory: write on the first disparity, read every issue
   always_ff @(posedge clock) begin
      if (issue && (d_ff == '0)) begin
         right_mem[wp_ff] <= cur_right_ff;
      end
      if (issue) begin
         rd_right_ff <= right_mem[ra];
      end
   end

   // right column valid bits, set once per entry after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         right_vld_ff <= '0;
         b_rvld_ff    <= 1'b0;
      end else if (issue) begin
         b_rvld_ff <= right_vld_ff[ra];
         if (d_ff == '0) begin
            right_vld_ff[wp_ff] <= 1'b1;
         end
      end
   end

   // stage b registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_d_ff         <= d_ff;
         b_h_ff         <= hp_ff;
         b_fresh_ff     <= cur_fresh_ff;
         b_zero_ff      <= cur_col_ff < COL_IDX_W'(d_ff);
         b_left_ff      <= cur_left_ff;
         b_new_right_ff <= cur_right_ff;
      end
   end

   // disparity zero uses the column that arrived with this request
   always_comb begin
      if (b_d_ff == '0) begin
         b_right_sel = b_new_right_ff;
      end else if (b_rvld_ff) begin
         b_right_sel = rd_right_ff;
      end else begin
         b_right_sel = '0;
      end
   end

   iwsad_col_sad #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_col_sad (
      .left_pixels  (b_left_ff),
      .right_pixels (b_right_sel),
      .force_zero   (b_zero_ff),
      .column_sad   (b_col_sad)
   );

   assign b_haddr = {b_d_ff, b_h_ff};
   assign c_haddr = {c_d_ff, c_h_ff};
   assign c_wr    = adv && c_valid_ff;

   // history and running-sum memories: read in b, written back from c
   always_ff @(posedge clock) begin
      if (adv && b_valid_ff) begin
         rd_hist_ff <= hist_mem[b_haddr];
         rd_run_ff  <= run_mem[b_d_ff];
      end
      if (c_wr) begin
         hist_mem[c_haddr] <= c_col_sad_ff;
         run_mem[c_d_ff]   <= c_new_run;
      end
   end

   // history valid bits; a row start clears them as its first disparity reads
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         c_hvld_ff   <= 1'b0;
      end else begin
         if (adv && b_valid_ff) begin
            c_hvld_ff <= hist_vld_ff[b_haddr];
         end
         if (adv && b_valid_ff && b_fresh_ff && (b_d_ff == '0)) begin
            hist_vld_ff <= '0;
         end else if (c_wr) begin
            hist_vld_ff[c_haddr] <= 1'b1;
         end
      end
   end

   // stage c registers and forwarding from the write in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && b_valid_ff) begin
         c_d_ff         <= b_d_ff;
         c_h_ff         <= b_h_ff;
         c_fresh_ff     <= b_fresh_ff;
         c_col_sad_ff   <= b_col_sad;
         c_hfwd_ff      <= c_wr && (c_haddr == b_haddr);
         c_hfwd_data_ff <= c_col_sad_ff;
         c_rfwd_ff      <= c_wr && (c_d_ff == b_d_ff);
         c_rfwd_data_ff <= c_new_run;
      end
   end

   // running sum update with saturation to the output width
   always_comb begin
      if (c_fresh_ff) begin
         c_leaving = '0;
      end else if (c_hfwd_ff) begin
         c_leaving = c_hfwd_data_ff;
      end else if (c_hvld_ff) begin
         c_leaving = rd_hist_ff;
      end else begin
         c_leaving = '0;
      end
      if (c_fresh_ff) begin
         c_run_old = '0;
      end else if (c_rfwd_ff) begin
         c_run_old = c_rfwd_data_ff;
      end else begin
         c_run_old = rd_run_ff;
      end
      c_new_run = c_run_old + RSUM_W'(c_col_sad_ff) - RSUM_W'(c_leaving);
      c_run_ext = CMP_W'(c_new_run);
      c_sad_out = (c_run_ext > CMP_W'(SAD_MAX)) ? SAD_MAX : c_run_ext[SAD_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_valid_ff) begin
         rsp_data_ff.disparity  <= DISP_W'(c_d_ff);
         rsp_data_ff.window_sad <= c_sad_out;
         rsp_data_ff.last       <= (c_d_ff == D_LAST);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // stages b and c both hold the same request
   assign bc_pair     = c_valid_ff && b_valid_ff && (b_d_ff != '0);
   assign rsp_is_last = rsp_valid_ff && rsp_data_ff.last;

   // disparities of one request stay adjacent through the pipeline
   `ASSERT_IMPL(a_op_order, bc_pair, b_d_ff == c_d_ff + DW'(1), "disparity order broken")
   // sequencer never runs past the last disparity
   `ASSERT_IMPL(a_d_range, cur_valid_ff, d_ff <= D_LAST, "disparity counter out of range")
   // the marked response carries the highest disparity
   `ASSERT_IMPL(a_last_disp, rsp_is_last, rsp_data_ff.disparity == DISP_TOP, "misplaced last")
   // a row start reaches stage c with all its disparities fresh
   `ASSERT_IMPL(a_fresh_group, bc_pair, b_fresh_ff == c_fresh_ff, "row start flag split")

endmodule

// ----- tb/tb.sv -----
// testbench for incremental_window_sad_disparity: random and directed columns,
// window sads predicted in-line and compared against every response
// depends on iwsad_pkg, iwsad_chan_if and the block's rtl
`timescale 1ns / 1ps

module tb;
   import iwsad_pkg::*;

   localparam int WIN            = WINDOW_SIZE_DEF;
   localparam int NDISP          = DISPARITIES_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 60;
   localparam int DRAIN_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 55;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iwsad_chan_if #(.payload_type(req_payload_type)) req_chan ();
   iwsad_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   incremental_window_sad_disparity #(
      .WINDOW_SIZE(WIN),
      .DISPARITIES(NDISP)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // predictor state: right column store, column sad history, window sums
   logic [7:0]  right_store [NDISP][WIN] = '{default: '0};
   logic [10:0] col_sad_hist [NDISP][WIN] = '{default: '0};
   int unsigned window_sum [NDISP] = '{default: 0};
   rsp_payload_type expected_sads[$];

   bit src_gaps_on = 1'b1;
   bit sink_gaps_on = 1'b1;
   bit long_hold_req = 1'b0;
   int fail_count = 0;
   int columns_sent = 0;
   int sads_checked = 0;
   int stall_count = 0;

   // compute the window sads one column causes and queue them
   function automatic void predict_window_sads(input req_payload_type item);
      int unsigned col_sad;
      int unsigned leaving;
      int unsigned sad;
      int lp;
      int rp;
      rsp_payload_type want;
      if (item.row_start) begin
         col_sad_hist = '{default: '0};
         window_sum = '{default: 0};
      end
      for (int d = NDISP - 1; d > 0; d--) right_store[d] = right_store[d-1];
      for (int r = 0; r < WIN; r++) right_store[0][r] = item.right_column[8*r +: 8];
      for (int d = 0; d < NDISP; d++) begin
         col_sad = 0;
         for (int r = 0; r < WIN; r++) begin
            lp = item.left_column[8*r +: 8];
            rp = right_store[d][r];
            col_sad += (lp > rp) ? lp - rp : rp - lp;
         end
         // columns left of the disparity have no match
         if (item.column_index < d) col_sad = 0;
         leaving = col_sad_hist[d][WIN-1];
         for (int r = WIN - 1; r > 0; r--) col_sad_hist[d][r] = col_sad_hist[d][r-1];
         col_sad_hist[d][0] = col_sad[10:0];
         window_sum[d] = window_sum[d] + col_sad - leaving;
         sad = (window_sum[d] > SAD_MAX) ? SAD_MAX : window_sum[d];
         want.disparity  = d[DISP_W-1:0];
         want.window_sad = sad[SAD_W-1:0];
         want.last       = (d == NDISP - 1);
         expected_sads.push_back(want);
      end
   endfunction

   // random column pair: mix of extreme, random and near-matching pixels
   function automatic req_payload_type make_item(input int col, input bit start);
      req_payload_type item;
      logic [7:0] lp;
      logic [7:0] rp;
      int delta;
      bit close_match;
      close_match = ($urandom_range(0, 1) == 1);
      for (int r = 0; r < WIN; r++) begin
         case ($urandom_range(0, 3))
            0: lp = 8'h00;
            1: lp = 8'hff;
            default: lp = 8'($urandom);
         endcase
         if (close_match) begin
            delta = int'(lp) + int'($urandom_range(0, 8)) - 4;
            rp = (delta < 0) ? 8'h00 : (delta > 255) ? 8'hff : delta[7:0];
         end else begin
            rp = 8'($urandom);
         end
         item.left_column[8*r +: 8]  = lp;
         item.right_column[8*r +: 8] = rp;
      end
      item.column_index = col[COL_IDX_W-1:0];
      item.row_start    = start;
      return item;
   endfunction

   // offer one request, optionally after an idle burst, until it is taken
   task automatic send_column(input req_payload_type item);
      if (src_gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (!req_chan.ready);
      predict_window_sads(item);
      columns_sent++;
   endtask

   // stop offering and wait for every outstanding response
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_sads.size() != 0) @(posedge clock);
   endtask

   // first columns of a row: guard zeroes disparities above the index
   task automatic test_guard_columns();
      for (int c = 0; c < 10; c++) send_column(make_item(c, c == 0));
   endtask

   // saturated, zero and alternating pixels, extreme column indexes
   task automatic test_extreme_pixels();
      req_payload_type item;
      item = '{left_column: '0, right_column: '0, column_index: 12'd0, row_start: 1'b1};
      send_column(item);
      item = '{left_column: '1, right_column: '0, column_index: 12'd1, row_start: 1'b0};
      send_column(item);
      item = '{left_column: '0, right_column: '1, column_index: 12'd2, row_start: 1'b0};
      send_column(item);
      item = '{left_column: '1, right_column: '1, column_index: 12'd3, row_start: 1'b0};
      send_column(item);
      item = '{left_column: 40'haaaaaaaaaa, right_column: 40'h5555555555,
               column_index: 12'hfff, row_start: 1'b0};
      send_column(item);
      item = '{left_column: 40'h5555555555, right_column: 40'haaaaaaaaaa,
               column_index: 12'haaa, row_start: 1'b0};
      send_column(item);
      // a full window of maximum differences
      for (int k = 0; k < 6; k++) begin
         item = '{left_column: '1, right_column: '0,
                  column_index: (k == 0) ? 12'h555 : 12'(2000 + k), row_start: 1'b0};
         send_column(item);
      end
   endtask

   // row start mid-stream clears sums but keeps the right column store
   task automatic test_row_restart();
      send_column(make_item(50, 1'b1));
      send_column(make_item(51, 1'b0));
      send_column(make_item(52, 1'b0));
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_back_pressure();
      long_hold_req = 1'b1;
      for (int k = 0; k < 8; k++) send_column(make_item(200 + k, k == 0));
   endtask

   // sender stops until the block is empty, then resumes the row
   task automatic test_drain_pause();
      send_column(make_item(0, 1'b1));
      send_column(make_item(1, 1'b0));
      pause_until_drained();
      send_column(make_item(2, 1'b0));
      send_column(make_item(3, 1'b0));
   endtask

   // mostly well-formed rows with random content, some stray columns
   task automatic test_random_rows();
      int sent;
      int row_len;
      int col;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 6) == 0) begin
            send_column(make_item($urandom_range(0, 4095), $urandom_range(0, 1) == 1));
            sent++;
         end else begin
            row_len = $urandom_range(3, 16);
            col = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4000) : 0;
            for (int k = 0; k < row_len; k++) send_column(make_item(col + k, k == 0));
            sent += row_len;
         end
      end
   endtask

   // back-to-back columns with no idling on either side
   task automatic test_full_rate();
      src_gaps_on  = 1'b0;
      sink_gaps_on = 1'b0;
      for (int k = 0; k < 15; k++) send_column(make_item(k, k == 0));
   endtask

   // receiver: ready with random stall bursts and one long hold
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each response with the oldest expected window sad
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_sads.size() == 0) begin
            $error("unexpected response: disparity %0d window_sad %0d last %0d",
                   rsp_chan.data.disparity, rsp_chan.data.window_sad, rsp_chan.data.last);
            fail_count++;
         end else begin
            want = expected_sads.pop_front();
            sads_checked++;
            if (rsp_chan.data.disparity !== want.disparity) begin
               $error("disparity: expected %0d, actual %0d",
                      want.disparity, rsp_chan.data.disparity);
               fail_count++;
            end
            if (rsp_chan.data.window_sad !== want.window_sad) begin
               $error("window_sad: expected %0d, actual %0d",
                      want.window_sad, rsp_chan.data.window_sad);
               fail_count++;
            end
            if (rsp_chan.data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_chan.data.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count == WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("incremental_window_sad_disparity regression: fail");
         $finish;
      end
   end

   // test sequence
   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_guard_columns();
      test_extreme_pixels();
      test_row_restart();
      test_back_pressure();
      test_drain_pause();
      test_random_rows();
      test_full_rate();

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d columns and %0d window sads: guard, saturated pixels,",
               columns_sent, sads_checked);
      $display("row restarts, long response stall, drain pause and full-rate rows");
      if (fail_count == 0 && expected_sads.size() == 0) begin
         $display("incremental_window_sad_disparity regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, expected_sads.size());
         $display("incremental_window_sad_disparity regression: fail");
      end
      $finish;
   end

endmodule
